>>> sv/iq_dc_offset_removal_top_defines.svh
// Assertion macros shared by the checkers of the I/Q DC offset removal block.
`ifndef IQ_DC_OFFSET_REMOVAL_TOP_DEFINES_SVH
`define IQ_DC_OFFSET_REMOVAL_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IQDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define IQDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/iqdc_pkg.sv
// Package with widths, constants and stage types of the I/Q DC offset removal block.
package iqdc_pkg;

  // Sample and output formats.
  localparam int SAMPLE_W      = 8;
  localparam int AVG_FRAC_BITS = 32;
  localparam int OUT_FRAC_BITS = 16;
  localparam int AVG_W         = AVG_FRAC_BITS + SAMPLE_W;
  localparam int DIFF_W        = AVG_W + 1;
  localparam int CORR_W        = DIFF_W - (AVG_FRAC_BITS - OUT_FRAC_BITS);

  // Smoothing factor is an unsigned fraction of 2^ALPHA_W.
  localparam int ALPHA_W = 32;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 32'd33554;

  // Stream widths: data padded to whole bytes.
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = ((CORR_W + 7) / 8) * 8;

  // Largest output magnitude: 255 sample steps with 16 fraction bits.
  localparam logic signed [CORR_W-1:0] CORR_MAX = 25'sd16711680;

  // First stage: sample with the difference to its channel average.
  typedef struct packed {
    logic                       quad;
    logic signed [SAMPLE_W-1:0] x;
    logic                       neg;
    logic [AVG_W-1:0]           mag;
  } stage1_t;

  // Second stage: sample with the updated channel average.
  typedef struct packed {
    logic                       quad;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [AVG_W-1:0]    avg;
  } stage2_t;

endpackage

>>> sv/iqdc_alpha_scale.sv
// Scales a difference magnitude by the smoothing factor, truncated toward zero.
module iqdc_alpha_scale (
  input  logic [iqdc_pkg::AVG_W-1:0]   mag_i,
  input  logic [iqdc_pkg::ALPHA_W-1:0] alpha_i,
  output logic [iqdc_pkg::AVG_W-1:0]   step_o
);
  import iqdc_pkg::*;

  logic [AVG_W-1:0]     hi_prod;
  logic [2*ALPHA_W-1:0] lo_prod;
  logic [AVG_W:0]       sum;

  // Two partial products: upper magnitude bits and lower word, each by alpha.
  assign hi_prod = mag_i[AVG_W-1:ALPHA_W] * alpha_i;
  assign lo_prod = mag_i[ALPHA_W-1:0] * alpha_i;

  // The lower product contributes only its upper word; the sum never exceeds mag.
  assign sum    = {1'b0, hi_prod} + {{(AVG_W+1-ALPHA_W){1'b0}}, lo_prod[2*ALPHA_W-1:ALPHA_W]};
  assign step_o = sum[AVG_W-1:0];

endmodule

>>> sv/iq_dc_offset_removal_top.sv
// Top level of the I/Q DC offset removal block with per-channel running averages.
//
//   Channel  Direction  Handshake                Payload
//   s_       in         s_tvalid_i / s_tready_o  s_tdata_i: sample_byte
//   m_       out        m_tvalid_o / m_tready_i  m_tdata_o: corrected_sample,
//                                                m_tuser_o: is_quadrature
//   cfg_     in         cfg_we_i                 cfg_wdata_i: smoothing_factor
//
// One request is taken per clock unless the output stalls; each result passes through
// stage 1, stage 2 and the output register. The rate is set by the average update, one
// alpha multiply and add per stage, which each channel needs only every second request.
// Reset clears both averages, starts with the in-phase channel and loads the
// default smoothing factor. A stall on the output backs up the stages in turn.
module iq_dc_offset_removal_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream.
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  input  logic [iqdc_pkg::IN_TDATA_W-1:0]   s_tdata_i,   // [7:0] sample_byte
  // Output stream.
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  output logic [iqdc_pkg::OUT_TDATA_W-1:0]  m_tdata_o,   // [24:0] corrected_sample, rest zero
  output logic                              m_tuser_o,   // [0] is_quadrature
  // Configuration.
  input  logic                              cfg_we_i,
  input  logic [iqdc_pkg::ALPHA_W-1:0]      cfg_wdata_i
);
  import iqdc_pkg::*;

  logic [ALPHA_W-1:0]      alpha_q;
  logic                    next_quad_q;
  logic signed [AVG_W-1:0] i_avg_q, i_avg_d;
  logic signed [AVG_W-1:0] q_avg_q, q_avg_d;

  logic    s1_v_q, s1_v_d, s2_v_q, s2_v_d, m_v_q, m_v_d;
  stage1_t s1_q, s1_d;
  stage2_t s2_q, s2_d;
  logic signed [CORR_W-1:0] corr_q, corr_d;
  logic                     quad_out_q;

  logic in_fire, s1_adv, s2_adv, out_free, s2_free;

  logic signed [SAMPLE_W-1:0] x_in;
  logic signed [AVG_W-1:0]    avg_in, avg_old;
  logic signed [DIFF_W-1:0]   diff_in, diff_abs, res;
  logic [AVG_W-1:0]           step;

  // Stage handshakes: each stage moves when the one after it has room.
  assign out_free   = !m_v_q || m_tready_i;
  assign s2_adv     = s2_v_q && out_free;
  assign s2_free    = !s2_v_q || out_free;
  assign s1_adv     = s1_v_q && s2_free;
  assign s_tready_o = !s1_v_q || s2_free;
  assign in_fire    = s_tvalid_i && s_tready_o;

  // Offset binary to two's complement, then difference to the channel average.
  assign x_in     = {~s_tdata_i[SAMPLE_W-1], s_tdata_i[SAMPLE_W-2:0]};
  assign avg_in   = next_quad_q ? q_avg_q : i_avg_q;
  assign diff_in  = {x_in[SAMPLE_W-1], x_in, {AVG_FRAC_BITS{1'b0}}}
                    - {avg_in[AVG_W-1], avg_in};
  assign diff_abs = diff_in[DIFF_W-1] ? -diff_in : diff_in;

  always_comb begin
    s1_d.quad = next_quad_q;
    s1_d.x    = x_in;
    s1_d.neg  = diff_in[DIFF_W-1];
    s1_d.mag  = diff_abs[AVG_W-1:0];
  end

  // Average update: step toward the sample by alpha times the difference.
  iqdc_alpha_scale u_scale (
    .mag_i   (s1_q.mag),
    .alpha_i (alpha_q),
    .step_o  (step)
  );

  assign avg_old = s1_q.quad ? q_avg_q : i_avg_q;

  always_comb begin
    s2_d.quad = s1_q.quad;
    s2_d.x    = s1_q.x;
    s2_d.avg  = s1_q.neg ? avg_old - $signed(step) : avg_old + $signed(step);
    i_avg_d   = i_avg_q;
    q_avg_d   = q_avg_q;
    if (s1_adv) begin
      if (s1_q.quad) begin
        q_avg_d = s2_d.avg;
      end else begin
        i_avg_d = s2_d.avg;
      end
    end
  end

  // Output value: sample minus updated average, floor-shifted to 16 fraction bits.
  assign res    = {s2_q.x[SAMPLE_W-1], s2_q.x, {AVG_FRAC_BITS{1'b0}}}
                  - {s2_q.avg[AVG_W-1], s2_q.avg};
  assign corr_d = res[DIFF_W-1 -: CORR_W];

  // Valid flags of the three stages.
  always_comb begin
    s1_v_d = s1_v_q;
    if (in_fire) begin
      s1_v_d = 1'b1;
    end else if (s1_adv) begin
      s1_v_d = 1'b0;
    end
    s2_v_d = s2_v_q;
    if (s1_adv) begin
      s2_v_d = 1'b1;
    end else if (s2_adv) begin
      s2_v_d = 1'b0;
    end
    m_v_d = m_v_q;
    if (s2_adv) begin
      m_v_d = 1'b1;
    end else if (m_tready_i) begin
      m_v_d = 1'b0;
    end
  end

  // Control state and running averages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      m_v_q       <= 1'b0;
      next_quad_q <= 1'b0;
      alpha_q     <= ALPHA_RESET;
      i_avg_q     <= '0;
      q_avg_q     <= '0;
    end else begin
      s1_v_q  <= s1_v_d;
      s2_v_q  <= s2_v_d;
      m_v_q   <= m_v_d;
      i_avg_q <= i_avg_d;
      q_avg_q <= q_avg_d;
      if (in_fire) begin
        next_quad_q <= !next_quad_q;
      end
      if (cfg_we_i) begin
        alpha_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers of the stages.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
    if (s1_adv) begin
      s2_q <= s2_d;
    end
    if (s2_adv) begin
      corr_q     <= corr_d;
      quad_out_q <= s2_q.quad;
    end
  end

  assign m_tvalid_o = m_v_q;
  assign m_tdata_o  = {{(OUT_TDATA_W-CORR_W){1'b0}}, corr_q};
  assign m_tuser_o  = quad_out_q;

endmodule

>>> sv/iqdc_checker.sv
// Port-level checker of the I/Q DC offset removal block, bound to the top level.
`include "iq_dc_offset_removal_top_defines.svh"

module iqdc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_tvalid_o,
  input logic                              m_tready_i,
  input logic [iqdc_pkg::OUT_TDATA_W-1:0]  m_tdata_o,
  input logic                              m_tuser_o
);
  import iqdc_pkg::*;

  logic                     exp_quad_q;
  logic                     out_fire;
  logic                     out_stall;
  logic                     pad_zero;
  logic                     corr_ok;
  logic [OUT_TDATA_W+1:0]   out_word;
  logic signed [CORR_W-1:0] corr;

  assign out_fire  = m_tvalid_o && m_tready_i;
  assign out_stall = m_tvalid_o && !m_tready_i;
  assign corr      = m_tdata_o[CORR_W-1:0];
  assign pad_zero  = (m_tdata_o[OUT_TDATA_W-1:CORR_W] == '0);
  assign corr_ok   = (corr <= CORR_MAX) && (corr >= -CORR_MAX);
  assign out_word  = {m_tvalid_o, m_tuser_o, m_tdata_o};

  // Channel expected on the next delivered result; results alternate from reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_quad_q <= 1'b0;
    end else if (out_fire) begin
      exp_quad_q <= !exp_quad_q;
    end
  end

  `IQDC_ASSERT_NOW(a_channel_alternates, out_fire, m_tuser_o == exp_quad_q, "channel order broken")

  `IQDC_ASSERT_NOW(a_pad_zero, m_tvalid_o, pad_zero, "tdata padding not zero")

  `IQDC_ASSERT_NOW(a_corr_range, m_tvalid_o, corr_ok, "corrected sample out of range")

  `IQDC_ASSERT_NEXT(a_out_hold, out_stall, $stable(out_word), "stalled result changed")

endmodule

bind iq_dc_offset_removal_top iqdc_checker u_iqdc_checker (.*);

>>> bench/tb_top.sv
// Self-checking testbench for the I/Q DC offset removal block.
`timescale 1ns / 100ps

module tb_top;
  import iqdc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;

  // One corrected sample as the block should return it.
  typedef struct packed {
    logic signed [CORR_W-1:0] corrected_sample;
    logic                     is_quadrature;
  } iq_result_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   s_tvalid_i  = 1'b0;
  logic                   s_tready_o;
  logic [IN_TDATA_W-1:0]  s_tdata_i   = '0;   // [7:0] sample_byte
  logic                   m_tvalid_o;
  logic                   m_tready_i  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata_o;          // [24:0] corrected_sample, rest zero
  logic                   m_tuser_o;          // [0] is_quadrature
  logic                   cfg_we_i    = 1'b0;
  logic [ALPHA_W-1:0]     cfg_wdata_i = '0;

  // Shadow copy of the channel averages, the I/Q phase and the smoothing factor.
  logic signed [AVG_W-1:0] in_phase_avg   = '0;
  logic signed [AVG_W-1:0] quadrature_avg = '0;
  logic                    next_quad      = 1'b0;
  logic [ALPHA_W-1:0]      alpha_shadow   = ALPHA_RESET;

  iq_result_t  pending_results[$];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  bit          steady_flow = 1'b0;

  iq_dc_offset_removal_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Clock with a 10 ns period.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Run guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Idle length: mostly none, sometimes short, rarely long.
  function automatic int unsigned draw_gap();
    int unsigned r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Advance the channel average of one request and form its corrected sample.
  function automatic iq_result_t predict_correction(logic [SAMPLE_W-1:0] sample_byte);
    longint      scaled_x;
    longint      avg;
    longint      diff;
    longint      out_full;
    logic [63:0] mag;
    logic [95:0] prod;
    logic [63:0] step;
    iq_result_t  res;
    scaled_x = (longint'(sample_byte) - 128) * (longint'(1) << AVG_FRAC_BITS);
    avg      = next_quad ? longint'(quadrature_avg) : longint'(in_phase_avg);
    diff     = scaled_x - avg;
    mag      = (diff < 0) ? -diff : diff;
    prod     = 96'(mag) * 96'(alpha_shadow);
    step     = prod[95:ALPHA_W];
    avg      = (diff < 0) ? avg - longint'(step) : avg + longint'(step);
    // The average moves toward the sample by a truncated step, per channel.
    if (next_quad) quadrature_avg = avg[AVG_W-1:0];
    else           in_phase_avg   = avg[AVG_W-1:0];
    // Arithmetic shift gives the floor into the output format.
    out_full             = (scaled_x - avg) >>> (AVG_FRAC_BITS - OUT_FRAC_BITS);
    res.corrected_sample = out_full[CORR_W-1:0];
    res.is_quadrature    = next_quad;
    next_quad            = ~next_quad;
    return res;
  endfunction

  // Sink side: random stalls unless a steady stretch is running.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready_i <= 1'b0;
    end else begin
      stall_left = draw_gap();
      if (stall_left > 0) begin
        stall_left--;
        m_tready_i <= 1'b0;
      end else begin
        m_tready_i <= 1'b1;
      end
    end
  end

  // Register writes, accepted requests and returned results, all seen at the rising edge.
  always @(posedge clk_i) begin : scoreboard
    iq_result_t want;
    if (rst_ni) begin
      if (cfg_we_i) alpha_shadow = cfg_wdata_i;
      if (s_tvalid_i && s_tready_o) pending_results.push_back(predict_correction(s_tdata_i));
      if (m_tvalid_o && m_tready_i) begin
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding: tdata %h tuser %b", m_tdata_o, m_tuser_o);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (m_tdata_o[CORR_W-1:0] !== want.corrected_sample) begin
            $error("corrected_sample: expected %0d, actual %0d", want.corrected_sample,
                   $signed(m_tdata_o[CORR_W-1:0]));
            fail_count++;
          end
          if (m_tdata_o[OUT_TDATA_W-1:CORR_W] !== '0) begin
            $error("tdata padding: expected 0, actual %h", m_tdata_o[OUT_TDATA_W-1:CORR_W]);
            fail_count++;
          end
          if (m_tuser_o !== want.is_quadrature) begin
            $error("is_quadrature: expected %b, actual %b", want.is_quadrature, m_tuser_o);
            fail_count++;
          end
        end
      end
    end
  end

  // Present one sample byte after a random gap and hold it until taken.
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample_byte);
    int unsigned gap;
    gap = draw_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= sample_byte;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic wait_drained();
    @(negedge clk_i);
    s_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Load a new smoothing factor once the stream is empty.
  task automatic write_alpha(input logic [ALPHA_W-1:0] alpha);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= alpha;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Random bytes with constant runs and extremes mixed in.
  task automatic send_random_bytes(input int unsigned count);
    int unsigned sent;
    int unsigned run_len;
    int unsigned r;
    logic [SAMPLE_W-1:0] run_byte;
    sent = 0;
    while (sent < count) begin
      if (sent % 64 == 0) steady_flow = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      if (r < 10) begin
        // A constant run pulls both averages toward one byte, the top extreme half the time.
        run_byte = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'(r * 25);
        run_len  = $urandom_range(4, 20);
        repeat (run_len) send_sample(run_byte);
        sent += run_len;
      end else if (r < 16) begin
        send_sample(($urandom_range(0, 2) == 0) ? 8'd128 : (r[0] ? 8'hFF : 8'h00));
        sent++;
      end else begin
        send_sample(8'($urandom_range(0, 255)));
        sent++;
      end
    end
    steady_flow = 1'b0;
  endtask

  // Default smoothing factor after reset, with the byte extremes.
  task automatic test_reset_default();
    logic [SAMPLE_W-1:0] bytes_list[8];
    bytes_list = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h81, 8'h01, 8'hFE, 8'h55};
    foreach (bytes_list[i]) send_sample(bytes_list[i]);
    wait_drained();
  endtask

  // Largest, smallest and zero smoothing factor; the averages carry over between them.
  task automatic test_alpha_extremes();
    write_alpha(32'hFFFF_FFFF);
    send_sample(8'h00);
    send_sample(8'hFF);
    send_sample(8'hFF);
    send_sample(8'h00);
    write_alpha(32'd1);
    send_sample(8'hAA);
    send_sample(8'h55);
    send_sample(8'h80);
    send_sample(8'h00);
    // With zero weight the averages stay put and the output is the sample minus the held average.
    write_alpha('0);
    send_sample(8'h00);
    send_sample(8'hFF);
    send_sample(8'h7F);
    send_sample(8'h81);
    wait_drained();
  endtask

  // Long random streams under several smoothing factors.
  task automatic test_random_streams();
    write_alpha($urandom());
    send_random_bytes(300);
    write_alpha(ALPHA_W'($urandom_range(1, 1 << 16)));
    send_random_bytes(250);
    write_alpha(32'hFFFF_FFFF - ALPHA_W'($urandom_range(0, 1 << 20)));
    send_random_bytes(250);
    write_alpha($urandom());
    send_random_bytes(250);
    write_alpha(ALPHA_RESET);
    send_random_bytes(150);
    wait_drained();
  endtask

  // The sender holds off mid-stream until the pipeline is empty, then resumes.
  task automatic test_pause_until_drained();
    write_alpha(32'h4000_0000);
    send_random_bytes(51);
    wait_drained();
    send_random_bytes(49);
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_default();
    test_alpha_extremes();
    test_random_streams();
    test_pause_until_drained();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
